// ===== design/diff_drive_odometry_defines.svh =====
// assertion macros shared by the odometry checker
`ifndef DIFF_DRIVE_ODOMETRY_DEFINES_SVH
`define DIFF_DRIVE_ODOMETRY_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DDO_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ddo_pkg.sv =====
// types, constants and helper functions for the odometry block
`default_nettype none

package ddo_pkg;

  localparam int unsigned CordicIterDefault = 16;
  localparam int unsigned AtanLen           = 24;
  localparam int unsigned MulDigit          = 4;
  localparam int unsigned MulSteps          = 6;
  localparam int unsigned DivSteps          = 24;

  localparam logic [19:0] CircReset     = 20'd13382;
  localparam logic [23:0] InvBaseReset  = 24'd327680;
  localparam logic [15:0] DeadBandReset = 16'd66;

  localparam logic signed [33:0] CordicGain = 34'sd652032874;
  localparam logic [17:0]        YawScale   = 18'd174993;
  localparam logic [57:0]        PosDivisor = 58'd16384000000;
  localparam logic [57:0]        PosHalf    = 58'd8192000000;

  typedef enum logic [1:0] {
    CFG_CIRC      = 2'd0,
    CFG_INV_BASE  = 2'd1,
    CFG_DEAD_BAND = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_VL,
    ST_VR,
    ST_W,
    ST_WT,
    ST_WK,
    ST_C1,
    ST_PX1,
    ST_PX2,
    ST_DX,
    ST_PY1,
    ST_PY2,
    ST_DY,
    ST_C2
  } state_e;

  // arctangent of 2^-i, binary angle with 2^32 per turn
  function automatic logic signed [33:0] atan_q30(logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:    r = 34'sh020000000;
      5'd1:    r = 34'sh012E4051E;
      5'd2:    r = 34'sh009FB385B;
      5'd3:    r = 34'sh0051111D4;
      5'd4:    r = 34'sh0028B0D43;
      5'd5:    r = 34'sh00145D7E1;
      5'd6:    r = 34'sh000A2F61E;
      5'd7:    r = 34'sh000517C55;
      5'd8:    r = 34'sh00028BE53;
      5'd9:    r = 34'sh000145F2F;
      5'd10:   r = 34'sh0000A2F98;
      5'd11:   r = 34'sh0000517CC;
      5'd12:   r = 34'sh000028BE6;
      5'd13:   r = 34'sh0000145F3;
      5'd14:   r = 34'sh00000A2FA;
      5'd15:   r = 34'sh00000517D;
      5'd16:   r = 34'sh0000028BE;
      5'd17:   r = 34'sh00000145F;
      5'd18:   r = 34'sh000000A30;
      5'd19:   r = 34'sh000000518;
      5'd20:   r = 34'sh00000028C;
      5'd21:   r = 34'sh000000146;
      5'd22:   r = 34'sh0000000A3;
      5'd23:   r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(logic signed [63:0] a);
    logic signed [23:0] r;
    if (a > 64'sd8388607) begin
      r = 24'sh7FFFFF;
    end else if (a < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = a[23:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] a);
    logic signed [31:0] r;
    if (a > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (a < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = a[31:0];
    end
    return r;
  endfunction

  // q30 to q1.14 with rounding, clamp and optional half-turn negation
  function automatic logic signed [15:0] trig_round(logic signed [33:0] a, logic flip);
    logic signed [33:0] t;
    logic signed [15:0] r;
    t = (a + 34'sd32768) >>> 16;
    if (t > 34'sd16384) begin
      r = 16'sd16384;
    end else if (t < -34'sd16384) begin
      r = -16'sd16384;
    end else begin
      r = t[15:0];
    end
    if (flip) begin
      r = -r;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== design/diff_drive_odometry.sv =====
// differential-drive odometry: wheel speeds to pose, heading, quaternion, body speed and turn rate
// one word at a time: input is taken only in idle, and idle follows only once the
// previous result is registered; each word passes the shared 4-bit digit
// multiplier (nine products), the radix-2 divider (two quotients) and the cordic
// reset clears pose and heading, reloads the register defaults and empties the output
`default_nettype none

module diff_drive_odometry import ddo_pkg::*; #(
  parameter int unsigned CORDIC_ITERATIONS = CordicIterDefault
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // input word
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // left_dir[1:0], left_rps[25:2], right_dir[27:26], right_rps[51:28], tick_us[69:52]
  input  wire logic [71:0]  s_axis_tdata,
  // result word
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading[79:64], quat_z[95:80], quat_w[111:96],
  // body_speed[135:112], turn_rate[159:136]
  output logic [159:0]      m_axis_tdata,
  // register writes
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [1:0]   cfg_index_i,
  input  wire logic [23:0]  cfg_data_i
);

  // iterations beyond the arctangent table length add nothing
  localparam int unsigned IterEff  = (CORDIC_ITERATIONS > AtanLen) ? AtanLen : CORDIC_ITERATIONS;
  localparam logic [4:0]  IterLast = 5'(IterEff);
  localparam logic [4:0]  MulLast  = 5'(MulSteps);
  localparam logic [4:0]  DivLast  = 5'(DivSteps);

  state_e state_q, state_d;
  logic [4:0] cnt_q;
  logic [4:0] step_last;
  logic       step_done;
  logic       in_acc, out_free;

  // configuration and pose state
  logic [19:0]        circ_q;
  logic [23:0]        ibase_q;
  logic [15:0]        dband_q;
  logic [15:0]        yaw_q;
  logic signed [31:0] x_q, y_q;

  // latched input
  logic        lzero_q, lneg_q, rzero_q, rneg_q;
  logic [23:0] rrps_q;
  logic [17:0] t_q;

  // speeds
  logic signed [28:0] vl_q;
  logic signed [23:0] v_q, w_q;

  // digit-serial multiplier
  logic [63:0] ma_q, acc_q;
  logic [23:0] mb_q;
  logic        neg_q;

  // cordic
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               flip_q;
  logic signed [15:0] s_q;

  // radix-2 divider
  logic [57:0] rem_q, dv_q;
  logic [23:0] quo_q;

  // output register
  logic         ovalid_q;
  logic [159:0] out_q;

  // input fields
  logic [1:0]  in_ldir, in_rdir;
  logic [23:0] in_lrps, in_rrps;
  logic [17:0] in_tick;

  assign in_ldir = s_axis_tdata[1:0];
  assign in_lrps = s_axis_tdata[25:2];
  assign in_rdir = s_axis_tdata[27:26];
  assign in_rrps = s_axis_tdata[51:28];
  assign in_tick = s_axis_tdata[69:52];

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid_q || m_axis_tready;

  // ---------------------------------------------------------------------------
  // datapath arithmetic between the registers
  // ---------------------------------------------------------------------------
  logic [63:0]        mul_sum;
  logic [27:0]        spd_mag;
  logic signed [28:0] vl_new, vr_new;
  logic signed [29:0] v_sum, v_diff;
  logic [29:0]        diff_mag;
  logic signed [23:0] v_new, w_new;
  logic [23:0]        w_mag, v_mag;
  logic signed [63:0] acc_s;
  logic [15:0]        dyaw, yaw_new;
  logic [31:0]        ang_raw, ang_rot;
  logic               ang_flip;
  logic signed [33:0] x_shift, y_shift, atan_i;
  logic signed [15:0] cos_r, sin_r;
  logic [15:0]        cos_mag, sin_mag;
  logic               div_ge;
  logic signed [32:0] pos_step;
  logic signed [31:0] x_new, y_new;

  // one digit of the multiplier operand per cycle
  assign mul_sum = acc_q + ma_q * 64'(mb_q[MulDigit-1:0]);

  // wheel speed: round half up on the magnitude, then the direction sign
  assign spd_mag = 28'((acc_q + 64'd32768) >> 16);
  assign vl_new  = lzero_q ? '0 : (lneg_q ? -$signed({1'b0, spd_mag}) : $signed({1'b0, spd_mag}));
  assign vr_new  = rzero_q ? '0 : (rneg_q ? -$signed({1'b0, spd_mag}) : $signed({1'b0, spd_mag}));

  // body speed is the floored mean, the difference feeds the turn rate
  assign v_sum    = 30'(vl_q) + 30'(vr_new);
  assign v_new    = sat24(64'(v_sum >>> 1));
  assign v_diff   = 30'(vr_new) - 30'(vl_q);
  assign diff_mag = v_diff[29] ? 30'(-v_diff) : 30'(v_diff);

  // products are built on magnitudes, the sign comes back here
  assign acc_s = neg_q ? -$signed(acc_q) : $signed(acc_q);
  assign w_new = sat24((acc_s + 64'sd32768) >>> 16);
  assign w_mag = w_new[23] ? 24'(-w_new) : 24'(w_new);
  assign v_mag = v_q[23] ? 24'(-v_q) : 24'(v_q);

  // yaw step rounded to the nearest binary-angle unit, wraps modulo a turn
  assign dyaw    = 16'((acc_s + 64'sh0000_0080_0000_0000) >>> 40);
  assign yaw_new = yaw_q + dyaw;

  // cordic start: full yaw for the position, half yaw for the quaternion
  assign ang_raw  = (state_q == ST_WK) ? {yaw_new, 16'd0} : {1'b0, yaw_q, 15'd0};
  assign ang_flip = ang_raw[31] ^ ang_raw[30];
  assign ang_rot  = ang_flip ? (ang_raw + 32'h8000_0000) : ang_raw;

  assign x_shift = cx_q >>> cnt_q;
  assign y_shift = cy_q >>> cnt_q;
  assign atan_i  = atan_q30(cnt_q);

  assign cos_r   = trig_round(cx_q, flip_q);
  assign sin_r   = trig_round(cy_q, flip_q);
  assign cos_mag = cos_r[15] ? 16'(-cos_r) : 16'(cos_r);
  assign sin_mag = s_q[15] ? 16'(-s_q) : 16'(s_q);

  // restoring division on the magnitude, quotient one bit a cycle
  assign div_ge   = rem_q >= dv_q;
  assign pos_step = neg_q ? -$signed({9'd0, quo_q}) : $signed({9'd0, quo_q});
  assign x_new    = sat32(64'(x_q) + 64'(pos_step));
  assign y_new    = sat32(64'(y_q) + 64'(pos_step));

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    case (state_q)
      ST_C1, ST_C2: step_last = IterLast;
      ST_DX, ST_DY: step_last = DivLast;
      ST_IDLE:      step_last = '0;
      default:      step_last = MulLast;
    endcase
  end

  assign step_done = (cnt_q == step_last);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_VL;
      ST_VL:   if (step_done) state_d = ST_VR;
      ST_VR:   if (step_done) state_d = ST_W;
      ST_W:    if (step_done) state_d = ST_WT;
      ST_WT:   if (step_done) state_d = ST_WK;
      ST_WK:   if (step_done) state_d = ST_C1;
      ST_C1:   if (step_done) state_d = ST_PX1;
      ST_PX1:  if (step_done) state_d = ST_PX2;
      ST_PX2:  if (step_done) state_d = ST_DX;
      ST_DX:   if (step_done) state_d = ST_PY1;
      ST_PY1:  if (step_done) state_d = ST_PY2;
      ST_PY2:  if (step_done) state_d = ST_DY;
      ST_DY:   if (step_done) state_d = ST_C2;
      // wait here while the previous result is still unread
      ST_C2:   if (step_done && out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    cfg_ready_o   = 1'b1;
    m_axis_tvalid = ovalid_q;
    m_axis_tdata  = out_q;
  end

  // control, configuration and pose
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      circ_q   <= CircReset;
      ibase_q  <= InvBaseReset;
      dband_q  <= DeadBandReset;
      yaw_q    <= '0;
      x_q      <= '0;
      y_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q != state_d) begin
        cnt_q <= '0;
      end else if (!step_done) begin
        cnt_q <= cnt_q + 5'd1;
      end

      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_CIRC:      circ_q  <= cfg_data_i[19:0];
          CFG_INV_BASE:  ibase_q <= cfg_data_i;
          CFG_DEAD_BAND: dband_q <= cfg_data_i[15:0];
          default:       ;
        endcase
      end

      if (state_q == ST_WK && step_done) begin
        yaw_q <= yaw_new;
      end
      if (state_q == ST_DX && step_done) begin
        x_q <= x_new;
      end
      if (state_q == ST_DY && step_done) begin
        y_q <= y_new;
      end

      if (m_axis_tvalid && m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
      if (state_q == ST_C2 && step_done && out_free) begin
        ovalid_q <= 1'b1;
      end
    end
  end

  // working registers of the datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          lzero_q <= (in_ldir == DIR_STOP) || (in_lrps < {8'd0, dband_q});
          lneg_q  <= (in_ldir != DIR_FWD);
          rzero_q <= (in_rdir == DIR_STOP) || (in_rrps < {8'd0, dband_q});
          rneg_q  <= (in_rdir != DIR_FWD);
          rrps_q  <= in_rrps;
          t_q     <= in_tick;
          ma_q    <= 64'(in_lrps);
          mb_q    <= 24'(circ_q);
          acc_q   <= '0;
        end
      end

      ST_C1, ST_C2: begin
        if (!step_done) begin
          if (!cz_q[33]) begin
            cx_q <= cx_q - y_shift;
            cy_q <= cy_q + x_shift;
            cz_q <= cz_q - atan_i;
          end else begin
            cx_q <= cx_q + y_shift;
            cy_q <= cy_q - x_shift;
            cz_q <= cz_q + atan_i;
          end
        end else if (state_q == ST_C1) begin
          s_q   <= sin_r;
          ma_q  <= 64'(v_mag);
          mb_q  <= 24'(cos_mag);
          neg_q <= v_q[23] ^ cos_r[15];
          acc_q <= '0;
        end else if (out_free) begin
          out_q <= {w_q, v_q, cos_r, sin_r, yaw_q, y_q, x_q};
        end
      end

      ST_DX, ST_DY: begin
        if (!step_done) begin
          if (div_ge) begin
            rem_q <= rem_q - dv_q;
          end
          quo_q <= {quo_q[22:0], div_ge};
          dv_q  <= dv_q >> 1;
        end else if (state_q == ST_DX) begin
          ma_q  <= 64'(v_mag);
          mb_q  <= 24'(sin_mag);
          neg_q <= v_q[23] ^ s_q[15];
          acc_q <= '0;
        end else begin
          cx_q   <= CordicGain;
          cy_q   <= '0;
          cz_q   <= 34'($signed(ang_rot));
          flip_q <= ang_flip;
        end
      end

      default: begin
        // multiplier states
        if (!step_done) begin
          acc_q <= mul_sum;
          ma_q  <= ma_q << MulDigit;
          mb_q  <= mb_q >> MulDigit;
        end else begin
          case (state_q)
            ST_VL: begin
              vl_q  <= vl_new;
              ma_q  <= 64'(rrps_q);
              mb_q  <= 24'(circ_q);
              acc_q <= '0;
            end
            ST_VR: begin
              v_q   <= v_new;
              ma_q  <= 64'(diff_mag);
              mb_q  <= ibase_q;
              neg_q <= v_diff[29];
              acc_q <= '0;
            end
            ST_W: begin
              w_q   <= w_new;
              ma_q  <= 64'(w_mag);
              mb_q  <= 24'(t_q);
              neg_q <= w_new[23];
              acc_q <= '0;
            end
            ST_WT: begin
              ma_q  <= acc_q;
              mb_q  <= 24'(YawScale);
              acc_q <= '0;
            end
            ST_WK: begin
              cx_q   <= CordicGain;
              cy_q   <= '0;
              cz_q   <= 34'($signed(ang_rot));
              flip_q <= ang_flip;
            end
            ST_PX1, ST_PY1: begin
              ma_q  <= acc_q;
              mb_q  <= 24'(t_q);
              acc_q <= '0;
            end
            ST_PX2, ST_PY2: begin
              rem_q <= acc_q[57:0] + PosHalf;
              dv_q  <= PosDivisor << (DivSteps - 1);
              quo_q <= '0;
            end
            default: ;
          endcase
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ddo_checker.sv =====
// port-level checks for the odometry block, bound to its top level
`default_nettype none

`include "diff_drive_odometry_defines.svh"

module ddo_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [159:0] m_axis_tdata
);

  `DDO_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result word changed while stalled")

  `DDO_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again right after an accept")

  `DDO_ASSERT_SAME(a_result_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready), "result appeared without work in progress")

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
